### src/ipsd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipsd_pkg
// Shared widths, result codes and header text for the IPS patch stream decoder.
// ----------------------------------------------------------------------------
package ipsd_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned KIND_W    = 2;
	localparam int unsigned ADDR_W    = 25;
	localparam int unsigned LEN_W     = 16;
	localparam int unsigned OFFSET_W  = 24;

	localparam logic [2:0] HDR_LEN      = 3'd5;
	localparam logic [2:0] OFFSET_BYTES = 3'd3;
	localparam logic [2:0] SIZE_BYTES   = 3'd2;

	// "EOF" as a big-endian three-byte offset
	localparam logic [OFFSET_W-1:0] END_MARK = 24'h454F46;

	localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FILL   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REJECT = 2'd2;
	localparam logic [KIND_W-1:0] KIND_END    = 2'd3;

	// Expected header byte at each position of "PATCH"
	function automatic logic [BYTE_W-1:0] header_char(input logic [2:0] idx);
		logic [BYTE_W-1:0] ch;
		ch = 8'h00;
		unique case (idx)
			3'd0: ch = 8'h50;
			3'd1: ch = 8'h41;
			3'd2: ch = 8'h54;
			3'd3: ch = 8'h43;
			3'd4: ch = 8'h48;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage
`default_nettype wire

### src/ips_patch_stream_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ips_patch_stream_decoder
// Parses an IPS patch byte stream: checks the header, then turns each record
// into byte writes or fill commands, and reports a bad header or the end marker.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | patch_byte[7:0], first_byte
//  out     | out_valid / out_ready| kind[1:0], address[24:0],
//          |                      | run_length[15:0], value[7:0]
//
//  One byte accepted per cycle unless a held result stalls it; a result passes the
//  input register, then the result register, and is set by the single parse stage.
//  A byte yields zero or one result; matching header bytes, offsets other than
//  the end marker and size bytes yield none.
//  Reset puts the parser in the header phase with all fields cleared.
//  With out_valid high and out_ready low the result register holds and the
//  input register holds its beat; in_ready is high while it can move on.
// ----------------------------------------------------------------------------
module ips_patch_stream_decoder (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [ipsd_pkg::BYTE_W-1:0]       patch_byte,
	input  wire logic                              first_byte,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [ipsd_pkg::KIND_W-1:0]            kind,
	output logic [ipsd_pkg::ADDR_W-1:0]            address,
	output logic [ipsd_pkg::LEN_W-1:0]             run_length,
	output logic [ipsd_pkg::BYTE_W-1:0]            value
);

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_REJECT = 3'd1;
	localparam logic [2:0] PH_OFFSET = 3'd2;
	localparam logic [2:0] PH_SIZE   = 3'd3;
	localparam logic [2:0] PH_DATA   = 3'd4;
	localparam logic [2:0] PH_FILL   = 3'd5;
	localparam logic [2:0] PH_DONE   = 3'd6;

	// input register
	logic                          valid_s1;
	logic [ipsd_pkg::BYTE_W-1:0]   byte_s1;
	logic                          first_s1;

	// parser state
	logic [2:0]                    phase_q;
	logic [2:0]                    field_count_q;
	logic [ipsd_pkg::ADDR_W-1:0]   record_offset_q;
	logic [ipsd_pkg::LEN_W-1:0]    remaining_q;
	logic                          run_mode_q;

	// result register
	logic                          out_valid_q;
	logic [ipsd_pkg::KIND_W-1:0]   kind_q;
	logic [ipsd_pkg::ADDR_W-1:0]   address_q;
	logic [ipsd_pkg::LEN_W-1:0]    run_length_q;
	logic [ipsd_pkg::BYTE_W-1:0]   value_q;

	logic advance;
	logic parse_go;

	// current state after a possible restart
	logic [2:0]                    ph_c;
	logic [2:0]                    fc_c;
	logic [ipsd_pkg::ADDR_W-1:0]   off_c;
	logic [ipsd_pkg::LEN_W-1:0]    rem_c;
	logic                          run_c;
	logic [2:0]                    fc_inc;
	logic [ipsd_pkg::ADDR_W-1:0]   off_shift;
	logic [ipsd_pkg::LEN_W-1:0]    rem_shift;
	logic [ipsd_pkg::LEN_W-1:0]    rem_dec;

	// next state and result
	logic [2:0]                    ph_n;
	logic [2:0]                    fc_n;
	logic [ipsd_pkg::ADDR_W-1:0]   off_n;
	logic [ipsd_pkg::LEN_W-1:0]    rem_n;
	logic                          run_n;
	logic                          emit;
	logic [ipsd_pkg::KIND_W-1:0]   kind_n;
	logic [ipsd_pkg::ADDR_W-1:0]   addr_n;
	logic [ipsd_pkg::LEN_W-1:0]    len_n;
	logic [ipsd_pkg::BYTE_W-1:0]   val_n;

	assign advance  = !out_valid_q || out_ready;
	assign parse_go = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_comb begin
		ph_c  = first_s1 ? PH_HEADER : phase_q;
		fc_c  = first_s1 ? 3'd0 : field_count_q;
		off_c = first_s1 ? '0 : record_offset_q;
		rem_c = first_s1 ? '0 : remaining_q;
		run_c = first_s1 ? 1'b0 : run_mode_q;

		fc_inc    = fc_c + 3'd1;
		off_shift = {1'b0, off_c[ipsd_pkg::OFFSET_W-ipsd_pkg::BYTE_W-1:0], byte_s1};
		rem_shift = {rem_c[ipsd_pkg::LEN_W-ipsd_pkg::BYTE_W-1:0], byte_s1};
		rem_dec   = rem_c - 16'd1;

		ph_n   = ph_c;
		fc_n   = fc_c;
		off_n  = off_c;
		rem_n  = rem_c;
		run_n  = run_c;
		emit   = 1'b0;
		kind_n = ipsd_pkg::KIND_WRITE;
		addr_n = '0;
		len_n  = '0;
		val_n  = '0;

		unique case (ph_c)
			PH_HEADER: begin
				if (fc_c >= ipsd_pkg::HDR_LEN || byte_s1 != ipsd_pkg::header_char(fc_c)) begin
					ph_n   = PH_REJECT;
					fc_n   = 3'd0;
					emit   = 1'b1;
					kind_n = ipsd_pkg::KIND_REJECT;
				end else if (fc_inc == ipsd_pkg::HDR_LEN) begin
					ph_n  = PH_OFFSET;
					fc_n  = 3'd0;
					off_n = '0;
				end else begin
					fc_n = fc_inc;
				end
			end
			PH_OFFSET: begin
				off_n = off_shift;
				fc_n  = fc_inc;
				if (fc_inc >= ipsd_pkg::OFFSET_BYTES) begin
					fc_n = 3'd0;
					if (off_shift[ipsd_pkg::OFFSET_W-1:0] == ipsd_pkg::END_MARK) begin
						ph_n   = PH_DONE;
						emit   = 1'b1;
						kind_n = ipsd_pkg::KIND_END;
					end else begin
						ph_n  = PH_SIZE;
						rem_n = '0;
						run_n = 1'b0;
					end
				end
			end
			PH_SIZE: begin
				rem_n = rem_shift;
				fc_n  = fc_inc;
				if (fc_inc >= ipsd_pkg::SIZE_BYTES) begin
					fc_n = 3'd0;
					// zero size: the next two bytes are the run count
					priority if (run_c) begin
						ph_n = PH_FILL;
					end else if (rem_shift == '0) begin
						run_n = 1'b1;
					end else begin
						ph_n = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				emit   = 1'b1;
				kind_n = ipsd_pkg::KIND_WRITE;
				addr_n = off_c;
				len_n  = 16'd1;
				val_n  = byte_s1;
				off_n  = off_c + 25'd1;
				rem_n  = rem_dec;
				if (rem_dec == '0) begin
					ph_n  = PH_OFFSET;
					off_n = '0;
				end
			end
			PH_FILL: begin
				emit   = 1'b1;
				kind_n = ipsd_pkg::KIND_FILL;
				addr_n = off_c;
				len_n  = rem_c;
				val_n  = byte_s1;
				ph_n   = PH_OFFSET;
				run_n  = 1'b0;
				rem_n  = '0;
				off_n  = '0;
			end
			default: begin
				// rejected or ended: drop the byte
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= patch_byte;
			first_s1 <= first_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_HEADER;
			field_count_q   <= 3'd0;
			record_offset_q <= '0;
			remaining_q     <= '0;
			run_mode_q      <= 1'b0;
		end else if (parse_go) begin
			phase_q         <= ph_n;
			field_count_q   <= fc_n;
			record_offset_q <= off_n;
			remaining_q     <= rem_n;
			run_mode_q      <= run_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (parse_go && emit) begin
			kind_q       <= kind_n;
			address_q    <= addr_n;
			run_length_q <= len_n;
			value_q      <= val_n;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign address    = address_q;
	assign run_length = run_length_q;
	assign value      = value_q;

`ifndef SYNTH
	a_status_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (kind_q == ipsd_pkg::KIND_REJECT || kind_q == ipsd_pkg::KIND_END)
		|-> address_q == '0 && run_length_q == '0 && value_q == '0)
		else $error("status result carries non-zero fields");

	a_write_len_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == ipsd_pkg::KIND_WRITE |-> run_length_q == 16'd1)
		else $error("byte write with run length other than one");

	a_dead_phase_silent: assert property (@(posedge clk) disable iff (!arst_n)
		parse_go && !first_s1 && (phase_q == PH_DONE || phase_q == PH_REJECT)
		|=> !out_valid_q)
		else $error("result produced after end or reject");

	a_header_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HEADER |-> field_count_q < ipsd_pkg::HDR_LEN)
		else $error("header byte count overran");

	a_run_mode_phase: assert property (@(posedge clk) disable iff (!arst_n)
		run_mode_q |-> phase_q == PH_SIZE || phase_q == PH_FILL)
		else $error("run mode set outside size or fill phase");
`endif

endmodule
`default_nettype wire
